// ===== src/tvi_pkg.sv =====
// Shared constants and types for the timestamped vector interpolator.
// No dependencies; every other file refers to it by scoped names.
package tvi_pkg;

  localparam int unsigned Depth     = 64;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned FillW     = AddrW + 1;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned QuoW      = FracBits + 1;
  localparam int unsigned StampW    = 62;
  localparam int unsigned CompW     = 32;
  localparam int unsigned NComp     = 6;
  localparam int unsigned IdxW      = $clog2(NComp);
  localparam int unsigned CntW      = $clog2(QuoW);

  // Transaction kind carried on kind_i
  typedef enum logic {
    KindPush  = 1'b0,
    KindQuery = 1'b1
  } kind_e;

  typedef logic [CompW-1:0] comp_t;
  typedef comp_t [NComp-1:0] comp_vec_t;

  // Handshake between the sequencer and the divider
  typedef struct packed {
    logic go;
    logic done;
  } div_ctl_t;

endpackage

// ===== src/timestamped_vector_interpolator.sv =====
// Top level: FIFO pointers, query sequencer, shared multiplier and result registers.
// Depends on tvi_pkg, tvi_store and tvi_div.
//
// Channel   | Handshake               | Payload
// ----------+-------------------------+-------------------------------------------
// input     | start, busy             | kind_i, stamp_i, lin_*_i, ang_*_i
// result    | done_o (one-cycle pulse)| valid_res_o, out_stamp_o, out_*_o
//
// A push yields no result. A query on an empty FIFO answers in the cycle after
// acceptance. Otherwise the query examines each head entry with a registered
// memory read, then a compare; an interpolated answer then runs the ratio
// divider (one bit a cycle) and the shared multiplier (a multiply, then an add,
// for each component). Reset clears pointers and the sequencer; the memories keep
// no reset. The receiver cannot stall.
module timestamped_vector_interpolator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind_i,
  input  logic [tvi_pkg::StampW-1:0]  stamp_i,
  input  logic signed [31:0]          lin_x_i,
  input  logic signed [31:0]          lin_y_i,
  input  logic signed [31:0]          lin_z_i,
  input  logic signed [31:0]          ang_x_i,
  input  logic signed [31:0]          ang_y_i,
  input  logic signed [31:0]          ang_z_i,
  output logic                        done_o,
  output logic                        valid_res_o,
  output logic [tvi_pkg::StampW-1:0]  out_stamp_o,
  output logic signed [31:0]          out_lin_x_o,
  output logic signed [31:0]          out_lin_y_o,
  output logic signed [31:0]          out_lin_z_o,
  output logic signed [31:0]          out_ang_x_o,
  output logic signed [31:0]          out_ang_y_o,
  output logic signed [31:0]          out_ang_z_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHK, S_DIVGO, S_DIVW, S_MUL, S_ADD
  } state_e;

  localparam int unsigned ProdW = tvi_pkg::CompW + 1 + tvi_pkg::QuoW + 1;

  state_e                        state_q;
  logic [tvi_pkg::AddrW-1:0]     head_q;
  logic [tvi_pkg::FillW-1:0]     fill_q;
  logic                          popped_q;
  logic [tvi_pkg::StampW-1:0]    tgt_q, old_stamp_q;
  tvi_pkg::comp_vec_t            old_c_q, new_c_q, res_q;
  logic [tvi_pkg::IdxW-1:0]      idx_q;
  logic signed [ProdW-1:0]       prod_q;
  logic [tvi_pkg::QuoW-1:0]      quo_q;
  logic                          done_q, valid_q;
  logic [tvi_pkg::StampW-1:0]    ostamp_q;

  logic                          accept, push, full;
  logic [tvi_pkg::AddrW-1:0]     wslot;
  tvi_pkg::comp_vec_t            wcomp;
  logic [tvi_pkg::StampW-1:0]    rstamp;
  tvi_pkg::comp_vec_t            rcomp;
  tvi_pkg::div_ctl_t             div_ctl;
  logic [tvi_pkg::QuoW-1:0]      div_quo;
  logic signed [tvi_pkg::CompW:0] diff;
  logic [tvi_pkg::CompW-1:0]     scaled;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign push   = accept && (kind_i == tvi_pkg::KindPush);
  assign full   = (fill_q == tvi_pkg::FillW'(tvi_pkg::Depth));
  // Overwrite the oldest slot when full
  assign wslot  = full ? head_q : head_q + fill_q[tvi_pkg::AddrW-1:0];
  assign wcomp  = {ang_z_i, ang_y_i, ang_x_i, lin_z_i, lin_y_i, lin_x_i};

  tvi_store u_store (
    .clk_i    (clk_i),
    .we_i     (push),
    .waddr_i  (wslot),
    .wstamp_i (stamp_i),
    .wcomp_i  (wcomp),
    .raddr_i  (head_q),
    .rstamp_o (rstamp),
    .rcomp_o  (rcomp)
  );

  assign div_ctl.go = (state_q == S_DIVGO);

  tvi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_ctl.go),
    .num_i  (tgt_q - old_stamp_q),
    .den_i  (rstamp - old_stamp_q),
    .done_o (div_ctl.done),
    .quo_o  (div_quo)
  );

  // Shared multiplier operand and floored shift of its product
  assign diff   = $signed({new_c_q[idx_q][tvi_pkg::CompW-1], new_c_q[idx_q]})
                - $signed({old_c_q[idx_q][tvi_pkg::CompW-1], old_c_q[idx_q]});
  assign scaled = prod_q[tvi_pkg::FracBits +: tvi_pkg::CompW];

  // Sequencer, pointers and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      fill_q   <= '0;
      popped_q <= 1'b0;
      done_q   <= 1'b0;
      valid_q  <= 1'b0;
      idx_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (push) begin
            if (full) begin
              head_q <= head_q + 1'b1;
            end else begin
              fill_q <= fill_q + 1'b1;
            end
          end else if (accept) begin
            popped_q <= 1'b0;
            if (fill_q == '0) begin
              done_q  <= 1'b1;
              valid_q <= 1'b0;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_CHK;
        S_CHK: begin
          if (rstamp < tgt_q) begin
            // Pop the head and keep it as the older entry
            head_q   <= head_q + 1'b1;
            fill_q   <= fill_q - 1'b1;
            popped_q <= 1'b1;
            if (fill_q == tvi_pkg::FillW'(1)) begin
              done_q  <= 1'b1;
              valid_q <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_READ;
            end
          end else if (!popped_q) begin
            done_q  <= 1'b1;
            valid_q <= 1'b0;
            state_q <= S_IDLE;
          end else if (rstamp == old_stamp_q) begin
            done_q  <= 1'b1;
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_DIVGO;
          end
        end
        S_DIVGO: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_ctl.done) begin
            idx_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ADD;
        S_ADD: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == tvi_pkg::IdxW'(tvi_pkg::NComp - 1)) begin
            done_q  <= 1'b1;
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        tgt_q    <= stamp_i;
        ostamp_q <= '0;
        res_q    <= '0;
      end
      S_CHK: begin
        if (rstamp < tgt_q) begin
          old_stamp_q <= rstamp;
          old_c_q     <= rcomp;
          ostamp_q    <= '0;
          res_q       <= '0;
        end else if (popped_q && rstamp == old_stamp_q) begin
          ostamp_q <= old_stamp_q;
          res_q    <= old_c_q;
        end else begin
          new_c_q  <= rcomp;
          ostamp_q <= popped_q ? tgt_q : '0;
          res_q    <= '0;
        end
      end
      S_DIVW: quo_q <= div_quo;
      S_MUL: prod_q <= ProdW'(diff * $signed({1'b0, quo_q}));
      S_ADD: res_q[idx_q] <= old_c_q[idx_q] + scaled;
      default: ;
    endcase
  end

  assign done_o      = done_q;
  assign valid_res_o = valid_q;
  assign out_stamp_o = ostamp_q;
  assign out_lin_x_o = res_q[0];
  assign out_lin_y_o = res_q[1];
  assign out_lin_z_o = res_q[2];
  assign out_ang_x_o = res_q[3];
  assign out_ang_y_o = res_q[4];
  assign out_ang_z_o = res_q[5];

  // Fill never exceeds the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= tvi_pkg::FillW'(tvi_pkg::Depth))
    else $error("fill count beyond depth");

  // A result follows only a busy cycle or an accepted transaction
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a query in flight");

  // A push yields no result
  a_push_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !kind_i) |=> !done_o)
    else $error("result after a push");

  // An invalid result carries a zero stamp
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (out_stamp_o == '0))
    else $error("invalid result with nonzero stamp");

endmodule

// ===== src/tvi_store.sv =====
// Sample memories: stamp store and six-component row store.
// One write port, one registered read port. Depends on tvi_pkg.
module tvi_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [tvi_pkg::AddrW-1:0]   waddr_i,
  input  logic [tvi_pkg::StampW-1:0]  wstamp_i,
  input  tvi_pkg::comp_vec_t          wcomp_i,
  input  logic [tvi_pkg::AddrW-1:0]   raddr_i,
  output logic [tvi_pkg::StampW-1:0]  rstamp_o,
  output tvi_pkg::comp_vec_t          rcomp_o
);

  logic [tvi_pkg::StampW-1:0] stamp_mem [tvi_pkg::Depth];
  tvi_pkg::comp_vec_t         comp_mem  [tvi_pkg::Depth];

  // Write a pushed sample
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      stamp_mem[waddr_i] <= wstamp_i;
      comp_mem[waddr_i]  <= wcomp_i;
    end
  end

  // Register the read of the current head
  always_ff @(posedge clk_i) begin
    rstamp_o <= stamp_mem[raddr_i];
    rcomp_o  <= comp_mem[raddr_i];
  end

endmodule

// ===== src/tvi_div.sv =====
// Restoring divider for the interpolation ratio, one quotient bit a cycle.
// Gives floor(num * 2^FracBits / den) for 0 < num <= den. Depends on tvi_pkg.
module tvi_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [tvi_pkg::StampW-1:0]  num_i,
  input  logic [tvi_pkg::StampW-1:0]  den_i,
  output logic                        done_o,
  output logic [tvi_pkg::QuoW-1:0]    quo_o
);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [tvi_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [tvi_pkg::StampW:0]   rem_q, rem_d;
  logic [tvi_pkg::StampW-1:0] den_q, den_d;
  logic [tvi_pkg::QuoW-1:0]   quo_q, quo_d;
  logic [tvi_pkg::StampW:0]   trial;
  logic                       ge;

  // Shift the remainder except on the integer step, then compare and subtract
  always_comb begin
    trial = (cnt_q == '0) ? rem_q : {rem_q[tvi_pkg::StampW-1:0], 1'b0};
    ge    = trial >= {1'b0, den_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (go_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = {1'b0, num_i};
      den_d = den_i;
      quo_d = '0;
    end else if (run_q) begin
      rem_d = ge ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[tvi_pkg::QuoW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tvi_pkg::CntW'(tvi_pkg::QuoW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
